FILE: hdl/sst_pkg.sv
// sst_pkg: shared types and codes for the sorted set table
`timescale 1ns / 1ps

package sst_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_VAL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_POS = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DUP  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } in_beat_t;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic [IDX_W-1:0]          found_index;
        logic signed [VALUE_W-1:0] read_data;
        logic [CNT_W-1:0]          entry_count;
    } out_beat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_SRCH_CMP,
        S_SHIFT,
        S_INS_WR,
        S_RD_WAIT,
        S_DONE
    } state_t;

endpackage

FILE: hdl/sorted_set_table_core.sv
// sorted_set_table_core: ascending, duplicate-free table of signed values in one ram
`timescale 1ns / 1ps
// command flow: clear, a full insert and an unused code go straight to the result, read waits on the ram;
// search, insert and delete by value first run a binary search of up to floor(log2(count))+1 probes
// (none on an empty table); insert then shifts the m entries above its slot up and writes the value,
// delete by value or position shifts the entries above the slot down, one entry per cycle
// throughput: one command at a time, next beat taken from the cycle in which out_valid rises
// reset: count and handshake state clear asynchronously, ram contents stay undefined

module sorted_set_table_core #(
    parameter int CAPACITY = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sst_pkg::in_beat_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output sst_pkg::out_beat_t out_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = CW + sst_pkg::POS_W;

    // control state
    sst_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            out_valid_reg, out_valid_next;

    // command and datapath registers
    logic [sst_pkg::CMD_W-1:0]          cmd_reg, cmd_next;
    logic signed [sst_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [CW-1:0]                      lo_reg, lo_next;
    logic [CW-1:0]                      hi_reg, hi_next;
    logic                               hit_reg, hit_next;
    logic [AW-1:0]                      slot_reg, slot_next;
    logic [AW-1:0]                      rd_ptr_reg, rd_ptr_next;
    logic                               pend_reg, pend_next;
    logic [AW-1:0]                      pend_addr_reg, pend_addr_next;
    logic [CW-1:0]                      rem_reg, rem_next;
    logic                               up_reg, up_next;
    logic [sst_pkg::STAT_W-1:0]         res_status_reg, res_status_next;
    logic [AW-1:0]                      res_idx_reg, res_idx_next;
    logic [sst_pkg::VALUE_W-1:0]        res_data_reg, res_data_next;
    sst_pkg::out_beat_t                 out_data_reg, out_data_next;

    // ram port
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [sst_pkg::VALUE_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [sst_pkg::VALUE_W-1:0] ram_rdata;

    // helpers
    logic [CW:0]   mid_sum;
    logic [AW-1:0] mid;
    logic          pos_ok;
    logic [AW-1:0] dn_slot;
    logic [CW-1:0] dn_moves;
    logic [CW-1:0] up_moves;

    sst_ram #(
        .WIDTH (sst_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == sst_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // binary search midpoint, always below count while lo < hi
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = AW'(mid_sum >> 1);

    assign pos_ok = PW'(in_data.position) < PW'(count_reg);

    // delete shift setup: slot from the position field at accept, else from the search
    assign dn_slot  = (state_reg == sst_pkg::S_IDLE) ? AW'(in_data.position) : AW'(lo_reg);
    assign dn_moves = count_reg - CW'(1) - CW'(dn_slot);
    // insert shift setup: entries from the insert slot up to the top move up by one
    assign up_moves = count_reg - lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sst_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        value_reg      <= value_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        hit_reg        <= hit_next;
        slot_reg       <= slot_next;
        rd_ptr_reg     <= rd_ptr_next;
        pend_reg       <= pend_next;
        pend_addr_reg  <= pend_addr_next;
        rem_reg        <= rem_next;
        up_reg         <= up_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_data_reg   <= res_data_next;
        out_data_reg   <= out_data_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        cmd_next        = cmd_reg;
        value_next      = value_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        rd_ptr_next     = rd_ptr_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        rem_next        = rem_reg;
        up_next         = up_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_data_next   = res_data_reg;
        out_data_next   = out_data_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;

        // output beat taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            sst_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = in_data.command;
                    value_next      = in_data.value;
                    lo_next         = '0;
                    hi_next         = count_reg;
                    hit_next        = 1'b0;
                    pend_next       = 1'b0;
                    res_status_next = sst_pkg::STAT_MISS;
                    res_idx_next    = '0;
                    res_data_next   = '0;
                    state_next      = sst_pkg::S_DONE;
                    unique case (in_data.command)
                        sst_pkg::CMD_CLEAR:
                        begin
                            count_next      = '0;
                            res_status_next = sst_pkg::STAT_OK;
                        end
                        sst_pkg::CMD_INSERT:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                res_status_next = sst_pkg::STAT_FULL;
                            end
                            else
                            begin
                                state_next = sst_pkg::S_SRCH;
                            end
                        end
                        sst_pkg::CMD_DEL_VAL, sst_pkg::CMD_SEARCH:
                        begin
                            state_next = sst_pkg::S_SRCH;
                        end
                        sst_pkg::CMD_DEL_POS:
                        begin
                            if (pos_ok)
                            begin
                                slot_next = dn_slot;
                                if (dn_moves == '0)
                                begin
                                    count_next      = count_reg - CW'(1);
                                    res_status_next = sst_pkg::STAT_OK;
                                    res_idx_next    = dn_slot;
                                end
                                else
                                begin
                                    up_next     = 1'b0;
                                    rd_ptr_next = dn_slot + AW'(1);
                                    rem_next    = dn_moves;
                                    state_next  = sst_pkg::S_SHIFT;
                                end
                            end
                        end
                        sst_pkg::CMD_READ:
                        begin
                            if (pos_ok)
                            begin
                                slot_next  = AW'(in_data.position);
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(in_data.position);
                                state_next = sst_pkg::S_RD_WAIT;
                            end
                        end
                        default:
                        begin
                            // unused codes: miss, table untouched
                        end
                    endcase
                end
            end

            sst_pkg::S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = mid;
                    state_next = sst_pkg::S_SRCH_CMP;
                end
                else
                begin
                    // lo is the lower bound; hit means the entry there equals the value
                    state_next = sst_pkg::S_DONE;
                    unique case (cmd_reg)
                        sst_pkg::CMD_INSERT:
                        begin
                            if (hit_reg)
                            begin
                                res_status_next = sst_pkg::STAT_DUP;
                            end
                            else
                            begin
                                slot_next = AW'(lo_reg);
                                if (up_moves == '0)
                                begin
                                    state_next = sst_pkg::S_INS_WR;
                                end
                                else
                                begin
                                    up_next     = 1'b1;
                                    rd_ptr_next = AW'(count_reg - CW'(1));
                                    rem_next    = up_moves;
                                    state_next  = sst_pkg::S_SHIFT;
                                end
                            end
                        end
                        sst_pkg::CMD_DEL_VAL:
                        begin
                            if (hit_reg)
                            begin
                                slot_next = dn_slot;
                                if (dn_moves == '0)
                                begin
                                    count_next      = count_reg - CW'(1);
                                    res_status_next = sst_pkg::STAT_OK;
                                    res_idx_next    = dn_slot;
                                end
                                else
                                begin
                                    up_next     = 1'b0;
                                    rd_ptr_next = dn_slot + AW'(1);
                                    rem_next    = dn_moves;
                                    state_next  = sst_pkg::S_SHIFT;
                                end
                            end
                        end
                        default:
                        begin
                            // search
                            if (hit_reg)
                            begin
                                res_status_next = sst_pkg::STAT_OK;
                                res_idx_next    = AW'(lo_reg);
                            end
                        end
                    endcase
                end
            end

            sst_pkg::S_SRCH_CMP:
            begin
                if ($signed(ram_rdata) < value_reg)
                begin
                    lo_next = CW'(mid) + CW'(1);
                end
                else
                begin
                    hi_next  = CW'(mid);
                    hit_next = ($signed(ram_rdata) == value_reg);
                end
                state_next = sst_pkg::S_SRCH;
            end

            sst_pkg::S_SHIFT:
            begin
                // write back the entry read last cycle, read the next one
                ram_we    = pend_reg;
                ram_waddr = pend_addr_reg;
                ram_wdata = ram_rdata;
                if (rem_reg != '0)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = rd_ptr_reg;
                    pend_next      = 1'b1;
                    pend_addr_next = up_reg ? rd_ptr_reg + AW'(1) : rd_ptr_reg - AW'(1);
                    rd_ptr_next    = up_reg ? rd_ptr_reg - AW'(1) : rd_ptr_reg + AW'(1);
                    rem_next       = rem_reg - CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (up_reg)
                    begin
                        state_next = sst_pkg::S_INS_WR;
                    end
                    else
                    begin
                        count_next      = count_reg - CW'(1);
                        res_status_next = sst_pkg::STAT_OK;
                        res_idx_next    = slot_reg;
                        state_next      = sst_pkg::S_DONE;
                    end
                end
            end

            sst_pkg::S_INS_WR:
            begin
                ram_we          = 1'b1;
                ram_waddr       = slot_reg;
                ram_wdata       = value_reg;
                count_next      = count_reg + CW'(1);
                res_status_next = sst_pkg::STAT_OK;
                res_idx_next    = slot_reg;
                state_next      = sst_pkg::S_DONE;
            end

            sst_pkg::S_RD_WAIT:
            begin
                res_status_next = sst_pkg::STAT_OK;
                res_idx_next    = slot_reg;
                res_data_next   = ram_rdata;
                state_next      = sst_pkg::S_DONE;
            end

            sst_pkg::S_DONE:
            begin
                // load the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.status      = res_status_reg;
                    out_data_next.found_index = sst_pkg::IDX_W'(res_idx_reg);
                    out_data_next.read_data   = res_data_reg;
                    out_data_next.entry_count = sst_pkg::CNT_W'(count_reg);
                    state_next                = sst_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sst_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/sst_ram.sv
// sst_ram: generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/sst_checker.sv
// sst_checker: port-level assertions for the sorted set table, bound to sorted_set_table_core
`timescale 1ns / 1ps

module sst_checker #(
    parameter int CAPACITY = 64
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input sst_pkg::out_beat_t out_data
);

    localparam logic [sst_pkg::CNT_W-1:0] FULL_CNT = sst_pkg::CNT_W'(CAPACITY);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // one command in flight at a time
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a command is in flight");

    // full status only when the table holds capacity entries
    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == sst_pkg::STAT_FULL |-> out_data.entry_count == FULL_CNT)
        else $error("full status with table not full");

    // failed commands report zero index and data
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != sst_pkg::STAT_OK
            |-> out_data.found_index == '0 && out_data.read_data == '0)
        else $error("failed command with nonzero index or data");

    // count never above capacity
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (CAPACITY > 127) || (out_data.entry_count <= FULL_CNT))
        else $error("entry count above capacity");

endmodule

bind sorted_set_table_core sst_checker #(
    .CAPACITY (CAPACITY)
) u_sst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

FILE: tb/sv/tb.sv
// tb: self-checking testbench for sorted_set_table_core with a queue-fed driver and a monitor
`timescale 1ns / 1ps

module tb;

    localparam int SLOTS       = 64;      // table capacity of the instance
    localparam int HOLD_LEN    = 300;     // long receiver back-off, in cycles
    localparam int STALL_LIMIT = 3000;    // cycles with no beat on either side
    localparam int DRAIN_WAIT  = 200;     // tail after the last result, above worst latency
    localparam int PHASE_ITEMS = 170;     // random items per idling phase

    // command codes the block treats as no-ops
    localparam logic [sst_pkg::CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [sst_pkg::CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    localparam logic signed [sst_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [sst_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    sst_pkg::in_beat_t  in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    sst_pkg::out_beat_t out_data;

    // shadow of the table contents, updated as commands are accepted
    logic signed [sst_pkg::VALUE_W-1:0] set_vals [SLOTS];
    int                                 set_size = 0;

    sst_pkg::in_beat_t  cmd_queue   [$];   // commands waiting to be offered
    sst_pkg::out_beat_t expected_q  [$];   // predicted responses, oldest first

    int offered_cnt   = 0;
    int accepted_cnt  = 0;
    int stall_cycles  = 0;
    int error_count   = 0;

    int snd_idle_pct  = 0;
    int rcv_idle_pct  = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    int hold_cycles   = 0;

    // value pool for the current random episode
    logic signed [sst_pkg::VALUE_W-1:0] value_pool [128];
    int                                 pool_len = 1;

    sorted_set_table_core #(
        .CAPACITY (SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // table predictor
    // ------------------------------------------------------------------

    // slot holding v, or -1 when absent; entries are strictly ascending
    function automatic int find_slot(logic signed [sst_pkg::VALUE_W-1:0] v);
        int k;
        for (k = 0; k < set_size; k++)
        begin
            if (set_vals[k] == v)
                return k;
        end
        return -1;
    endfunction

    function automatic void remove_slot(int slot);
        int k;
        for (k = slot; k + 1 < set_size; k++)
            set_vals[k] = set_vals[k + 1];
        set_size--;
    endfunction

    // apply one command to the shadow table and return the response it yields
    function automatic sst_pkg::out_beat_t apply_command(sst_pkg::in_beat_t beat);
        sst_pkg::out_beat_t                 res;
        logic signed [sst_pkg::VALUE_W-1:0] v;
        int                                 at;
        int                                 k;
        int                                 pos;
        res        = '0;
        res.status = sst_pkg::STAT_MISS;
        v          = beat.value;
        pos        = int'(beat.position);
        case (beat.command)
            sst_pkg::CMD_CLEAR:
            begin
                set_size   = 0;
                res.status = sst_pkg::STAT_OK;
            end
            sst_pkg::CMD_INSERT:
            begin
                // fullness wins over the duplicate test
                if (set_size >= SLOTS)
                begin
                    res.status = sst_pkg::STAT_FULL;
                end
                else
                begin
                    at = 0;
                    while (at < set_size && set_vals[at] < v)
                        at++;
                    if (at < set_size && set_vals[at] == v)
                    begin
                        res.status = sst_pkg::STAT_DUP;
                    end
                    else
                    begin
                        for (k = set_size; k > at; k--)
                            set_vals[k] = set_vals[k - 1];
                        set_vals[at]    = v;
                        set_size++;
                        res.status      = sst_pkg::STAT_OK;
                        res.found_index = sst_pkg::IDX_W'(at);
                    end
                end
            end
            sst_pkg::CMD_DEL_VAL:
            begin
                at = find_slot(v);
                if (at >= 0)
                begin
                    remove_slot(at);
                    res.status      = sst_pkg::STAT_OK;
                    res.found_index = sst_pkg::IDX_W'(at);
                end
            end
            sst_pkg::CMD_DEL_POS:
            begin
                if (pos < set_size)
                begin
                    remove_slot(pos);
                    res.status      = sst_pkg::STAT_OK;
                    res.found_index = sst_pkg::IDX_W'(pos);
                end
            end
            sst_pkg::CMD_SEARCH:
            begin
                at = find_slot(v);
                if (at >= 0)
                begin
                    res.status      = sst_pkg::STAT_OK;
                    res.found_index = sst_pkg::IDX_W'(at);
                end
            end
            sst_pkg::CMD_READ:
            begin
                if (pos < set_size)
                begin
                    res.status      = sst_pkg::STAT_OK;
                    res.found_index = sst_pkg::IDX_W'(pos);
                    res.read_data   = set_vals[pos];
                end
            end
            default:
            begin
                // unused codes: miss, table untouched
            end
        endcase
        res.entry_count = sst_pkg::CNT_W'(set_size);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_beat(input logic [sst_pkg::CMD_W-1:0] cmd,
                             input logic signed [sst_pkg::VALUE_W-1:0] v,
                             input logic [sst_pkg::POS_W-1:0] pos);
        sst_pkg::in_beat_t b;
        b.command  = cmd;
        b.value    = v;
        b.position = pos;
        cmd_queue.push_back(b);
    endtask

    // fresh value, biased toward the extremes and the values around zero
    function automatic logic signed [sst_pkg::VALUE_W-1:0] fresh_value();
        int r;
        r = $urandom_range(15, 0);
        case (r)
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [sst_pkg::VALUE_W-1:0] pick_value();
        if ($urandom_range(9, 0) == 0)
            return fresh_value();
        return value_pool[$urandom_range(pool_len - 1, 0)];
    endfunction

    function automatic logic [sst_pkg::POS_W-1:0] pick_pos();
        if ($urandom_range(1, 0) == 1)
            return sst_pkg::POS_W'($urandom_range(15, 0));
        return sst_pkg::POS_W'($urandom_range(63, 0));
    endfunction

    // kind 0 grows the table toward full, the other kinds churn it
    function automatic logic [sst_pkg::CMD_W-1:0] pick_command(int kind);
        int r;
        r = $urandom_range(99, 0);
        if (r < ((kind == 0) ? 70 : 35))
            return sst_pkg::CMD_INSERT;
        r = $urandom_range(99, 0);
        if (r < 20)
            return sst_pkg::CMD_DEL_VAL;
        if (r < 35)
            return sst_pkg::CMD_DEL_POS;
        if (r < 60)
            return sst_pkg::CMD_SEARCH;
        if (r < 90)
            return sst_pkg::CMD_READ;
        if (r < 95)
            return (kind == 1) ? sst_pkg::CMD_CLEAR : sst_pkg::CMD_SEARCH;
        return (r % 2 == 1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
    endfunction

    // episodes: clear, optional fill burst, then a random command mix over a value pool
    task automatic queue_random(int total);
        int queued;
        int kind;
        int len;
        int n;
        queued = 0;
        while (queued < total)
        begin
            kind     = $urandom_range(2, 0);
            pool_len = (kind == 0) ? 128 : (kind == 1) ? 40 : 6;
            for (n = 0; n < pool_len; n++)
                value_pool[n] = fresh_value();
            push_beat(sst_pkg::CMD_CLEAR, pick_value(), pick_pos());
            queued++;
            if (kind == 0)
            begin
                for (n = 0; n < SLOTS; n++)
                    push_beat(sst_pkg::CMD_INSERT, pick_value(), pick_pos());
                queued += SLOTS;
            end
            len = $urandom_range(120, 40);
            for (n = 0; n < len; n++)
                push_beat(pick_command(kind), pick_value(), pick_pos());
            queued += len;
        end
    endtask

    // wait until everything queued is accepted and every response is back
    task automatic drain();
        while (cmd_queue.size() != 0 || offered_cnt != accepted_cnt || expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_field(string name, logic [sst_pkg::VALUE_W-1:0] want,
                                logic [sst_pkg::VALUE_W-1:0] got);
        error_count++;
        $display("[%0t] mismatch %s: expected %0h, actual %0h", $time, name, want, got);
    endtask

    // ------------------------------------------------------------------
    // driver: presents one beat at a time, holds it until accepted
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // offered != accepted means the beat on the bus is still waiting
            if (!(in_valid && offered_cnt != accepted_cnt))
            begin
                if (cmd_queue.size() != 0 && $urandom_range(99, 0) >= snd_idle_pct)
                begin
                    in_data     <= cmd_queue.pop_front();
                    in_valid    <= 1'b1;
                    offered_cnt <= offered_cnt + 1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random back-pressure plus long holds on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (holds_done != hold_requests)
            begin
                out_ready <= 1'b0;
                if (hold_cycles == HOLD_LEN - 1)
                begin
                    hold_cycles <= 0;
                    holds_done  <= holds_done + 1;
                end
                else
                begin
                    hold_cycles <= hold_cycles + 1;
                end
            end
            else
            begin
                out_ready <= ($urandom_range(99, 0) >= rcv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: predicts on each accepted command, checks each response
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        sst_pkg::out_beat_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_q.push_back(apply_command(in_data));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    error_count++;
                    $display("[%0t] unexpected response: expected none, actual %h",
                             $time, out_data);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_data.status !== want.status)
                        report_field("status", sst_pkg::VALUE_W'(want.status),
                                     sst_pkg::VALUE_W'(out_data.status));
                    if (out_data.found_index !== want.found_index)
                        report_field("found_index", sst_pkg::VALUE_W'(want.found_index),
                                     sst_pkg::VALUE_W'(out_data.found_index));
                    if (out_data.read_data !== want.read_data)
                        report_field("read_data", want.read_data, out_data.read_data);
                    if (out_data.entry_count !== want.entry_count)
                        report_field("entry_count", sst_pkg::VALUE_W'(want.entry_count),
                                     sst_pkg::VALUE_W'(out_data.entry_count));
                end
            end
            // watchdog count: cycles with no beat on either channel
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // watchdog
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, extremes, duplicates, edges of the count
        push_beat(sst_pkg::CMD_SEARCH,  '0,      6'd0);
        push_beat(sst_pkg::CMD_READ,    '0,      6'd0);
        push_beat(sst_pkg::CMD_DEL_POS, '0,      6'd0);
        push_beat(sst_pkg::CMD_DEL_VAL, '0,      6'd0);
        push_beat(sst_pkg::CMD_INSERT,  '0,      6'd63);
        push_beat(sst_pkg::CMD_INSERT,  VAL_MAX, 6'd0);
        push_beat(sst_pkg::CMD_INSERT,  VAL_MIN, 6'd0);
        push_beat(sst_pkg::CMD_INSERT,  -1,      6'd0);
        push_beat(sst_pkg::CMD_INSERT,  1,       6'd0);
        push_beat(sst_pkg::CMD_INSERT,  '0,      6'd0);    // duplicate
        push_beat(sst_pkg::CMD_SEARCH,  VAL_MIN, 6'd0);
        push_beat(sst_pkg::CMD_SEARCH,  VAL_MAX, 6'd0);
        push_beat(sst_pkg::CMD_SEARCH,  5,       6'd0);    // absent
        push_beat(sst_pkg::CMD_READ,    '0,      6'd4);    // last occupied slot
        push_beat(sst_pkg::CMD_READ,    '0,      6'd5);    // slot equal to count
        push_beat(sst_pkg::CMD_READ,    VAL_MAX, 6'd63);
        push_beat(sst_pkg::CMD_DEL_VAL, VAL_MAX, 6'd0);
        push_beat(sst_pkg::CMD_DEL_POS, '0,      6'd0);
        push_beat(sst_pkg::CMD_DEL_POS, '0,      6'd3);    // slot equal to count
        push_beat(sst_pkg::CMD_DEL_POS, '0,      6'd1);
        push_beat(CMD_UNUSED_LO, VAL_MIN, 6'd63);
        push_beat(CMD_UNUSED_HI, VAL_MAX, 6'd21);
        push_beat(sst_pkg::CMD_READ,    '0,      6'd1);
        push_beat(sst_pkg::CMD_CLEAR,   VAL_MAX, 6'd63);
        push_beat(sst_pkg::CMD_READ,    '0,      6'd0);
        drain();

        // sender idles lightly, receiver heavily; one long receiver hold
        // while commands keep coming so the block backs up its input
        snd_idle_pct = 16;
        rcv_idle_pct = 64;
        queue_random(PHASE_ITEMS);
        hold_requests = hold_requests + 1;
        drain();

        // swapped idling; the drain above is the sender pause
        snd_idle_pct = 64;
        rcv_idle_pct = 16;
        queue_random(PHASE_ITEMS);
        drain();

        // full rate both sides
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        queue_random(PHASE_ITEMS);
        drain();

        // catch any stray response after the last expected one
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

FILE: sorted_set_table_core.f
hdl/sst_pkg.sv
hdl/sst_ram.sv
hdl/sorted_set_table_core.sv
hdl/sst_checker.sv
tb/sv/tb.sv
